// ===== rtl/serial_frame_switch_controller_top_macros.svh =====
// Assertion macros shared by the serial frame switch controller RTL.
// Depends on nothing; the asserting module supplies clk and rst_n.
`ifndef SERIAL_FRAME_SWITCH_CONTROLLER_TOP_MACROS_SVH
`define SERIAL_FRAME_SWITCH_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfsc_pkg.sv =====
// Shared types, codes and constants of the serial frame switch controller.
// Depends on nothing; used by every module of the block.
package sfsc_pkg;

  localparam int DefMaxPayload = 8;
  localparam int DefChannels   = 8;
  localparam int DefQueueDepth = 4;
  localparam int CfgIdxW       = 3;
  localparam int ReplyLen      = 6;

  localparam logic [7:0] RstHead       = 8'hAA;
  localparam logic [7:0] RstOwnAddr    = 8'h01;
  localparam logic [7:0] RstCodeSingle = 8'h01;
  localparam logic [7:0] RstCodeAll    = 8'h02;
  localparam logic [7:0] RstCodeMask   = 8'h03;
  localparam logic [7:0] RstCodeQuery  = 8'h04;
  localparam logic [7:0] RstCodeReply  = 8'h84;
  localparam logic [7:0] ReplyCount    = 8'h01;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEAD,
    REG_OWN_ADDR,
    REG_CODE_SINGLE,
    REG_CODE_ALL,
    REG_CODE_MASK,
    REG_CODE_QUERY,
    REG_CODE_REPLY
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SUM_BAD,
    ST_LEN_OVER,
    ST_ADDR_MISS,
    ST_ARG_ERR,
    ST_UNKNOWN
  } status_t;

  typedef enum logic [2:0] {
    OP_STATUS,
    OP_SINGLE,
    OP_ALL,
    OP_MASK,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t        op;
    status_t    status;
    logic [7:0] arg0;
    logic [7:0] arg1;
  } job_t;

  typedef struct packed {
    logic [7:0] head;
    logic [7:0] own_addr;
    logic [7:0] code_single;
    logic [7:0] code_all;
    logic [7:0] code_mask;
    logic [7:0] code_query;
    logic [7:0] code_reply;
  } cfg_t;

  function automatic logic [7:0] chan_mask(input int channels);
    logic [8:0] m;
    m = (9'd1 << channels) - 9'd1;
    return m[7:0];
  endfunction

endpackage

// ===== rtl/sfsc_queue.sv =====
// Short job queue between the frame parser and the executor.
// Depends on sfsc_pkg for the job type.
module sfsc_queue #(
  parameter int DEPTH = sfsc_pkg::DefQueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfsc_pkg::job_t    push_job,
  output logic              full,
  input  logic              pop,
  output sfsc_pkg::job_t    head_job,
  output logic              empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  sfsc_pkg::job_t  slot_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign full     = (cnt_r == FullCnt);
  assign empty    = (cnt_r == '0);
  assign head_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sfsc_parse.sv =====
// Frame parser: hunts for the head byte, tracks fields and checksum, and
// classifies every frame end into a job. Depends on sfsc_pkg.
module sfsc_parse #(
  parameter int MAX_PAYLOAD = sfsc_pkg::DefMaxPayload,
  parameter int CHANNELS    = sfsc_pkg::DefChannels
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sfsc_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_rx_byte,
  input  logic           q_full,
  output logic           q_push,
  output sfsc_pkg::job_t q_job
);

  localparam logic [7:0] MaxLen  = 8'(MAX_PAYLOAD);
  localparam logic [7:0] ChanLim = 8'(CHANNELS);

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_ADDR,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_SUM
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] p0_r, p0_nxt;
  logic [7:0] p1_r, p1_nxt;
  logic [7:0] cnt_inc;
  logic       fire;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign cnt_inc  = cnt_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    q_push    = 1'b0;
    q_job     = '{op: sfsc_pkg::OP_STATUS, status: sfsc_pkg::ST_OK, arg0: p0_r, arg1: p1_r};
    if (fire) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (in_rx_byte == cfg.head) begin
            cnt_nxt   = '0;
            len_nxt   = '0;
            xor_nxt   = '0;
            p0_nxt    = '0;
            p1_nxt    = '0;
            phase_nxt = PH_ADDR;
          end
        end
        PH_ADDR: begin
          addr_nxt  = in_rx_byte;
          xor_nxt   = in_rx_byte;
          phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          cmd_nxt   = in_rx_byte;
          xor_nxt   = xor_r ^ in_rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          xor_nxt = xor_r ^ in_rx_byte;
          len_nxt = in_rx_byte;
          cnt_nxt = '0;
          if (in_rx_byte > MaxLen) begin
            // Drop the frame and report it right away.
            len_nxt      = '0;
            phase_nxt    = PH_HEAD;
            q_push       = 1'b1;
            q_job.status = sfsc_pkg::ST_LEN_OVER;
          end else begin
            phase_nxt = (in_rx_byte == 8'd0) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          xor_nxt = xor_r ^ in_rx_byte;
          if (cnt_r == 8'd0) begin
            p0_nxt = in_rx_byte;
          end else if (cnt_r == 8'd1) begin
            p1_nxt = in_rx_byte;
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_nxt = PH_HEAD;
          cnt_nxt   = '0;
          len_nxt   = '0;
          q_push    = 1'b1;
          // First matching command code wins.
          priority if (in_rx_byte != xor_r) begin
            q_job.status = sfsc_pkg::ST_SUM_BAD;
          end else if (addr_r != cfg.own_addr) begin
            q_job.status = sfsc_pkg::ST_ADDR_MISS;
          end else if (cmd_r == cfg.code_single) begin
            if (len_r != 8'd2 || p0_r >= ChanLim || p1_r > 8'd1) begin
              q_job.status = sfsc_pkg::ST_ARG_ERR;
            end else begin
              q_job.op = sfsc_pkg::OP_SINGLE;
            end
          end else if (cmd_r == cfg.code_all) begin
            if (len_r != 8'd1 || p0_r > 8'd1) begin
              q_job.status = sfsc_pkg::ST_ARG_ERR;
            end else begin
              q_job.op = sfsc_pkg::OP_ALL;
            end
          end else if (cmd_r == cfg.code_mask) begin
            if (len_r != 8'd1) begin
              q_job.status = sfsc_pkg::ST_ARG_ERR;
            end else begin
              q_job.op = sfsc_pkg::OP_MASK;
            end
          end else if (cmd_r == cfg.code_query) begin
            if (len_r != 8'd0) begin
              q_job.status = sfsc_pkg::ST_ARG_ERR;
            end else begin
              q_job.op = sfsc_pkg::OP_QUERY;
            end
          end else begin
            q_job.status = sfsc_pkg::ST_UNKNOWN;
          end
        end
        default: begin
          phase_nxt = PH_HEAD;
          cnt_nxt   = '0;
          len_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      cnt_r   <= '0;
      len_r   <= '0;
      xor_r   <= '0;
      addr_r  <= '0;
      cmd_r   <= '0;
      p0_r    <= '0;
      p1_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
    end
  end

endmodule

// ===== rtl/sfsc_exec.sv =====
// Executor: pops jobs, owns the channel state, sends reply bytes and the
// status result through the output register. Depends on sfsc_pkg.
module sfsc_exec #(
  parameter int CHANNELS = sfsc_pkg::DefChannels
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sfsc_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  sfsc_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_kind,
  output logic [7:0]     out_tx_byte,
  output logic [2:0]     out_frame_status,
  output logic [7:0]     out_channel_bits,
  output logic           out_last
);

  localparam logic [7:0] ChanMask = sfsc_pkg::chan_mask(CHANNELS);
  localparam logic [2:0] StepEnd  = 3'(sfsc_pkg::ReplyLen);

  // Reply byte positions.
  localparam logic [2:0] RplHead  = 3'd0;
  localparam logic [2:0] RplAddr  = 3'd1;
  localparam logic [2:0] RplCode  = 3'd2;
  localparam logic [2:0] RplCount = 3'd3;
  localparam logic [2:0] RplBits  = 3'd4;
  localparam logic [2:0] RplSum   = 3'd5;

  logic [2:0] step_r, step_nxt;
  logic [7:0] chan_r, chan_nxt;
  logic       valid_r, valid_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] tx_r, tx_nxt;
  logic [2:0] status_r, status_nxt;
  logic [7:0] bits_r, bits_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic [7:0] single_bits;
  logic [7:0] reply_byte;

  assign load = !q_empty && (!valid_r || out_ready);

  always_comb begin
    single_bits = chan_r;
    single_bits[q_job.arg0[2:0]] = q_job.arg1[0];
  end

  always_comb begin
    unique case (step_r)
      RplHead:  reply_byte = cfg.head;
      RplAddr:  reply_byte = cfg.own_addr;
      RplCode:  reply_byte = cfg.code_reply;
      RplCount: reply_byte = sfsc_pkg::ReplyCount;
      RplBits:  reply_byte = chan_r;
      RplSum:   reply_byte = cfg.own_addr ^ cfg.code_reply ^ sfsc_pkg::ReplyCount ^ chan_r;
      default:  reply_byte = '0;
    endcase
  end

  always_comb begin
    step_nxt   = step_r;
    chan_nxt   = chan_r;
    valid_nxt  = valid_r && !out_ready;
    kind_nxt   = kind_r;
    tx_nxt     = tx_r;
    status_nxt = status_r;
    bits_nxt   = bits_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (q_job.op == sfsc_pkg::OP_QUERY && step_r != StepEnd) begin
        // Send one reply byte, hold the job.
        step_nxt   = step_r + 3'd1;
        kind_nxt   = 1'b1;
        tx_nxt     = reply_byte;
        status_nxt = sfsc_pkg::ST_OK;
        bits_nxt   = chan_r;
        last_nxt   = 1'b0;
      end else begin
        unique case (q_job.op)
          sfsc_pkg::OP_SINGLE: chan_nxt = single_bits & ChanMask;
          sfsc_pkg::OP_ALL:    chan_nxt = q_job.arg0[0] ? ChanMask : 8'd0;
          sfsc_pkg::OP_MASK:   chan_nxt = q_job.arg0 & ChanMask;
          default:             chan_nxt = chan_r;
        endcase
        step_nxt   = '0;
        q_pop      = 1'b1;
        kind_nxt   = 1'b0;
        tx_nxt     = '0;
        status_nxt = q_job.status;
        bits_nxt   = chan_nxt;
        last_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tx_r     <= tx_nxt;
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
    bits_r   <= bits_nxt;
    last_r   <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      chan_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      chan_r  <= chan_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_tx_byte      = tx_r;
  assign out_frame_status = status_r;
  assign out_channel_bits = bits_r;
  assign out_last         = last_r;

endmodule

// ===== rtl/serial_frame_switch_controller_top.sv =====
// Serial frame switch controller, top level. Takes one received byte per
// request and returns frame status results and reply bytes.
// Depends on sfsc_pkg, sfsc_parse, sfsc_queue, sfsc_exec and the macro header.
//
// A user's overview: bytes enter on in_rx_byte and the parser takes one per
// cycle whenever its job queue has room (in_ready low only with the queue
// full). Frames are head, address, command, length, data, checksum; the
// checksum is the XOR of address through the last data byte. Each frame end
// (checksum byte, or a length byte over MAX_PAYLOAD) pushes one job into a
// queue of QUEUE_DEPTH entries. The executor drains one result per cycle
// into the output register while out_ready does not hold it back: an
// ordinary frame end gives one status result, a channel query gives six
// reply bytes with out_kind high, then the status result with out_last
// high. The executor output rate sets the sustained throughput. Channel
// state lives in the executor and out_channel_bits shows it after the
// request that caused the result. Configuration registers (head byte, own
// address, four command codes, reply code) sit on the cfg_ port, index 0
// to 6; they are to be written only while the block is idle, and the block
// itself does not enforce this. cfg_ready is always high and other indexes
// are ignored.
module serial_frame_switch_controller_top #(
  parameter int MAX_PAYLOAD = sfsc_pkg::DefMaxPayload,
  parameter int CHANNELS    = sfsc_pkg::DefChannels,
  parameter int QUEUE_DEPTH = sfsc_pkg::DefQueueDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sfsc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [7:0]                   out_tx_byte,
  output logic [2:0]                   out_frame_status,
  output logic [7:0]                   out_channel_bits,
  output logic                         out_last
);

`include "serial_frame_switch_controller_top_macros.svh"

  localparam logic [7:0] ChanMask = sfsc_pkg::chan_mask(CHANNELS);

  sfsc_pkg::cfg_t cfg_r;
  logic           q_push, q_full, q_pop, q_empty;
  sfsc_pkg::job_t push_job, head_job;

  // Configuration registers: accept every write, drop unknown indexes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head        <= sfsc_pkg::RstHead;
      cfg_r.own_addr    <= sfsc_pkg::RstOwnAddr;
      cfg_r.code_single <= sfsc_pkg::RstCodeSingle;
      cfg_r.code_all    <= sfsc_pkg::RstCodeAll;
      cfg_r.code_mask   <= sfsc_pkg::RstCodeMask;
      cfg_r.code_query  <= sfsc_pkg::RstCodeQuery;
      cfg_r.code_reply  <= sfsc_pkg::RstCodeReply;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sfsc_pkg::reg_idx_t'(cfg_index))
        sfsc_pkg::REG_HEAD:        cfg_r.head        <= cfg_data;
        sfsc_pkg::REG_OWN_ADDR:    cfg_r.own_addr    <= cfg_data;
        sfsc_pkg::REG_CODE_SINGLE: cfg_r.code_single <= cfg_data;
        sfsc_pkg::REG_CODE_ALL:    cfg_r.code_all    <= cfg_data;
        sfsc_pkg::REG_CODE_MASK:   cfg_r.code_mask   <= cfg_data;
        sfsc_pkg::REG_CODE_QUERY:  cfg_r.code_query  <= cfg_data;
        sfsc_pkg::REG_CODE_REPLY:  cfg_r.code_reply  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: parse and classify each byte, push a job at every frame end.
  sfsc_parse #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .CHANNELS   (CHANNELS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // Queue: decouple the parser from the executor.
  sfsc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .head_job(head_job),
    .empty   (q_empty)
  );

  // Back: apply jobs to the channels and send results.
  sfsc_exec #(
    .CHANNELS(CHANNELS)
  ) u_exec (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_job           (head_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_tx_byte     (out_tx_byte),
    .out_frame_status(out_frame_status),
    .out_channel_bits(out_channel_bits),
    .out_last        (out_last)
  );

  // Never push a job into a full queue.
  `SFSC_ASSERT_NOW(a_no_overflow, q_push, !q_full, "job pushed into full queue")
  // Reply bytes are never the final result and carry no status.
  `SFSC_ASSERT_NOW(a_reply_shape, out_valid && out_kind,
                   !out_last && out_frame_status == sfsc_pkg::ST_OK,
                   "reply byte with status or last flag")
  // Channel bits at index CHANNELS and above stay off.
  `SFSC_ASSERT_NOW(a_chan_range, out_valid, (out_channel_bits & ~ChanMask) == 8'd0,
                   "channel bit beyond channel count set")
  // A popped job leaves a status result in the output register.
  `SFSC_ASSERT_NEXT(a_pop_status, q_pop, out_valid && !out_kind && out_last,
                    "job retired without status result")

endmodule
